@@ hw/rtl/dcp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and fixed constants for the distance constraint projection block.
// No dependencies; imported by the top level.
package dcp_pkg;

    localparam int FIELD_W = 32;
    localparam int REST_W  = 31;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_MASS = 1'd1;

    localparam logic [FIELD_W-1:0] TIME_STEP_RESET    = 32'd1092;
    localparam logic [FIELD_W-1:0] INVERSE_MASS_RESET = 32'd65536;

    typedef struct packed {
        logic signed [FIELD_W-1:0] first_x;
        logic signed [FIELD_W-1:0] first_y;
        logic signed [FIELD_W-1:0] first_z;
        logic signed [FIELD_W-1:0] second_x;
        logic signed [FIELD_W-1:0] second_y;
        logic signed [FIELD_W-1:0] second_z;
        logic        [REST_W-1:0]  rest_length;
        logic        [FIELD_W-1:0] compliance;
    } t_in;

    typedef struct packed {
        logic signed [FIELD_W-1:0] move_first_x;
        logic signed [FIELD_W-1:0] move_first_y;
        logic signed [FIELD_W-1:0] move_first_z;
        logic signed [FIELD_W-1:0] move_second_x;
        logic signed [FIELD_W-1:0] move_second_y;
        logic signed [FIELD_W-1:0] move_second_z;
    } t_out;

endpackage

@@ hw/rtl/dcp_delay.sv @@
`timescale 1ns / 1ps
// Enabled delay line that carries side data alongside the long arithmetic units.
// No dependencies.
module dcp_delay #(
    parameter int W = 8,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);

    logic [W-1:0] r_line [D];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_line[0] <= i_d;
            for (int k = 1; k < D; k++) begin
                r_line[k] <= r_line[k-1];
            end
        end
    end

    assign o_d = r_line[D-1];

endmodule

@@ hw/rtl/dcp_sqrt.sv @@
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per register stage.
// No dependencies; the stages advance only while i_en is high.
module dcp_sqrt #(
    parameter int IN_W = 66
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [IN_W-1:0]   i_rad,
    output logic [IN_W/2-1:0] o_root
);

    localparam int RB = IN_W / 2;
    localparam int RW = RB + 2;

    logic [RW-1:0]   r_rem  [RB];
    logic [RB-1:0]   r_root [RB];
    logic [IN_W-1:0] r_rad  [RB];

    for (genvar k = 0; k < RB; k++) begin : g_step
        logic [RW-1:0]   rem_prev;
        logic [RB-1:0]   root_prev;
        logic [IN_W-1:0] rad_prev;
        logic [RW-1:0]   rem_ext;
        logic [RW-1:0]   trial;
        logic            take;

        if (k == 0) begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign rad_prev  = i_rad;
        end else begin : g_next
            assign rem_prev  = r_rem[k-1];
            assign root_prev = r_root[k-1];
            assign rad_prev  = r_rad[k-1];
        end

        // bring down the next two radicand bits, try root*4+1
        assign rem_ext = {rem_prev[RW-3:0], rad_prev[IN_W-1 -: 2]};
        assign trial   = {root_prev, 2'b01};
        assign take    = (rem_ext >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= take ? (rem_ext - trial) : rem_ext;
                r_root[k] <= {root_prev[RB-2:0], take};
                r_rad[k]  <= rad_prev << 2;
            end
        end
    end

    assign o_root = r_root[RB-1];

endmodule

@@ hw/rtl/dcp_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per register stage.
// No dependencies; stages advance only while i_en is high; flags quotients wider than QW bits.
module dcp_div #(
    parameter int NW = 98,
    parameter int DW = 98,
    parameter int QW = 33
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo,
    output logic          o_ovf
);

    localparam int HW = NW - QW;
    localparam int CW = (HW > DW) ? HW : DW;

    logic [DW-1:0] r_rem [QW+1];
    logic [QW-1:0] r_low [QW+1];
    logic [QW-1:0] r_quo [QW+1];
    logic [DW-1:0] r_den [QW+1];
    logic          r_ovf [QW+1];

    logic [HW-1:0] w_hi;
    logic          w_ovf;

    // quotient does not fit (or divisor is zero) when the top part reaches the divisor
    assign w_hi  = i_num[NW-1:QW];
    assign w_ovf = (CW'(w_hi) >= CW'(i_den));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= DW'(w_hi);
            r_low[0] <= i_num[QW-1:0];
            r_quo[0] <= '0;
            r_den[0] <= i_den;
            r_ovf[0] <= w_ovf;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [DW:0] rem_ext;
        logic        ge;
        logic [DW:0] n_rem;

        assign rem_ext = {r_rem[k-1], r_low[k-1][QW-1]};
        assign ge      = (rem_ext >= {1'b0, r_den[k-1]});
        assign n_rem   = ge ? (rem_ext - {1'b0, r_den[k-1]}) : rem_ext;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem[DW-1:0];
                r_low[k] <= r_low[k-1] << 1;
                r_quo[k] <= {r_quo[k-1][QW-2:0], ge};
                r_den[k] <= r_den[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_quo = r_quo[QW];
    assign o_ovf = r_ovf[QW];

endmodule

@@ hw/rtl/distance_constraint_projection_top.sv @@
`timescale 1ns / 1ps
// Top level of the distance constraint projection pipeline.
// Depends on dcp_pkg, dcp_delay, dcp_sqrt and dcp_div.
//
// Usage
//   Input channel: i_valid / o_stall carry one constraint transaction (two
//   particle positions, rest length, compliance) in i_data.
//   Output channel: o_valid / i_stall carry one correction transaction per
//   input transaction in o_data, in order.
//   Configuration: i_cfg_we writes i_cfg_data to the register at i_cfg_idx
//   (time step, inverse mass); write only while the pipeline is empty.
//   Throughput: one transaction per cycle while the output is not stalled.
//   Pipeline length: set mainly by the compliance/dt^2 divider (one bit per stage,
//   32+2F quotient bits), then the correction divider (VALUE_WIDTH+1 bits).
//   Reset: clears all valid bits and loads the register reset values; the
//   block accepts a transaction in the first cycle after reset.
//   Stall: while the output register holds a result and i_stall is high the
//   whole pipeline holds and o_stall rises; nothing is dropped or repeated.
module distance_constraint_projection_top
    import dcp_pkg::*;
#(
    parameter int VALUE_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_in                  i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_out                 o_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [FIELD_W-1:0]   i_cfg_data
);

    // widths of the datapath
    localparam int DIFF_W = FIELD_W + 1;                  // p1 - p2
    localparam int SUM_W  = 2 * DIFF_W;                   // sum of squares
    localparam int LEN_W  = SUM_W / 2;                    // length
    localparam int AW     = FIELD_W + 2 * FRACTION_BITS;  // alpha
    localparam int DENA_W = AW + 1;                       // 2w + alpha
    localparam int MAG_W  = LEN_W;                        // |C|
    localparam int BASE_W = FIELD_W + MAG_W;              // w * |C|
    localparam int NUM_W  = BASE_W + DIFF_W;              // w * |C| * |L_i|
    localparam int DEN_W  = DENA_W + LEN_W;               // denom * length
    localparam int QW     = VALUE_WIDTH + 1;
    localparam int TSQ_W  = 2 * FIELD_W;
    localparam int CA     = (DENA_W + 2) / 3;             // denom chunk
    localparam int CB     = (BASE_W + 2) / 3;             // base chunk
    // stage numbers
    localparam int P      = AW + 2;                       // alpha ready
    localparam int D_LEN  = P - 3 - LEN_W;
    localparam int LAT    = P + QW + 6;

    localparam logic [63:0] MAX_POS = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;

    typedef struct packed {
        logic [2:0][DIFF_W-1:0] md;
        logic [2:0]             dneg;
        logic [REST_W-1:0]      rest;
        logic                   compnz;
    } t_side;

    typedef struct packed {
        logic [2:0] dneg;
        logic       cneg;
        logic       zero;
    } t_flags;

    function automatic logic [FIELD_W-1:0] f_sat(input logic negative, input logic ovf,
                                                 input logic [QW-1:0] q);
        logic [63:0] mag;
        logic [63:0] v;
        mag = 64'(q);
        if (negative) begin
            if (ovf || mag > MAX_POS + 64'd1) begin
                mag = MAX_POS + 64'd1;
            end
            v = 64'd0 - mag;
        end else begin
            if (ovf || mag > MAX_POS) begin
                mag = MAX_POS;
            end
            v = mag;
        end
        return v[FIELD_W-1:0];
    endfunction

    // ---------------- configuration and flow control ----------------
    logic [FIELD_W-1:0] r_time_step;
    logic [FIELD_W-1:0] r_inverse_mass;
    logic [TSQ_W-1:0]   r_tsq;
    logic [LAT-1:0]     r_vld;
    logic               w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step    <= TIME_STEP_RESET;
            r_inverse_mass <= INVERSE_MASS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TIME_STEP: begin
                    r_time_step <= i_cfg_data;
                end
                CFG_INVERSE_MASS: begin
                    r_inverse_mass <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // dt^2 follows the register in the next cycle, long before any item needs it
    always_ff @(posedge i_clk) begin
        r_tsq <= TSQ_W'(r_time_step) * TSQ_W'(r_time_step);
    end

    // advance everything unless a finished result is held by the receiver
    assign w_en    = !r_vld[LAT-1] || !i_stall;
    assign o_stall = !w_en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // ---------------- stage A: differences ----------------
    logic [2:0][FIELD_W-1:0] w_p1;
    logic [2:0][FIELD_W-1:0] w_p2;
    logic [2:0][DIFF_W-1:0]  n_d;
    logic [2:0][DIFF_W-1:0]  r_a_md;
    logic [2:0]              r_a_dneg;
    logic [REST_W-1:0]       r_a_rest;
    logic [FIELD_W-1:0]      r_a_comp;

    assign w_p1 = {i_data.first_z, i_data.first_y, i_data.first_x};
    assign w_p2 = {i_data.second_z, i_data.second_y, i_data.second_x};

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_d[j] = {w_p1[j][FIELD_W-1], w_p1[j]} - {w_p2[j][FIELD_W-1], w_p2[j]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                r_a_dneg[j] <= n_d[j][DIFF_W-1];
                r_a_md[j]   <= n_d[j][DIFF_W-1] ? (DIFF_W'(0) - n_d[j]) : n_d[j];
            end
            r_a_rest <= i_data.rest_length;
            r_a_comp <= i_data.compliance;
        end
    end

    // ---------------- stages B, C: squares and their sum ----------------
    logic [2:0][SUM_W-1:0] r_b_sq;
    logic [SUM_W-1:0]      r_c_sum;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                r_b_sq[j] <= SUM_W'(r_a_md[j]) * SUM_W'(r_a_md[j]);
            end
            r_c_sum <= r_b_sq[0] + r_b_sq[1] + r_b_sq[2];
        end
    end

    // ---------------- length and alpha, both ready at stage P ----------------
    logic [LEN_W-1:0] w_root;
    logic [LEN_W-1:0] w_len;
    logic [AW:0]      w_alpha_num;
    logic [AW-1:0]    w_alpha_quo;
    logic             w_alpha_ovf;
    t_side            w_side_a;
    t_side            w_side_p;

    dcp_sqrt #(.IN_W(SUM_W)) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r_c_sum),
        .o_root (w_root)
    );

    dcp_delay #(.W(LEN_W), .D(D_LEN)) u_len_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (w_root),
        .o_d   (w_len)
    );

    // alpha = compliance * 2^(2F) / dt^2
    assign w_alpha_num = (AW + 1)'({r_a_comp, {(2 * FRACTION_BITS){1'b0}}});

    dcp_div #(.NW(AW + 1), .DW(TSQ_W), .QW(AW)) u_alpha_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_alpha_num),
        .i_den (r_tsq),
        .o_quo (w_alpha_quo),
        .o_ovf (w_alpha_ovf)
    );

    assign w_side_a = '{md: r_a_md, dneg: r_a_dneg, rest: r_a_rest, compnz: |r_a_comp};

    dcp_delay #(.W($bits(t_side)), .D(P - 1)) u_side_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (w_side_a),
        .o_d   (w_side_p)
    );

    // ---------------- E1: denominator, constraint value, special cases -------
    logic [AW-1:0]          w_alpha;
    logic [MAG_W-1:0]       w_rest;
    logic                   w_cneg;
    logic [DENA_W-1:0]      r_e1_denom;
    logic [MAG_W-1:0]       r_e1_magc;
    logic [LEN_W-1:0]       r_e1_len;
    logic                   r_e1_cneg;
    logic                   r_e1_zero;
    logic [2:0][DIFF_W-1:0] r_e1_md;
    logic [2:0]             r_e1_dneg;

    // zero time step: alpha is zero for zero compliance, otherwise the item is void
    assign w_alpha = (r_time_step == '0) ? '0 : w_alpha_quo;
    assign w_rest  = MAG_W'(w_side_p.rest);
    assign w_cneg  = (w_len < w_rest);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e1_denom <= DENA_W'(w_alpha) + DENA_W'({r_inverse_mass, 1'b0});
            r_e1_magc  <= w_cneg ? (w_rest - w_len) : (w_len - w_rest);
            r_e1_len   <= w_len;
            r_e1_cneg  <= w_cneg;
            r_e1_zero  <= (w_len == '0) || ((w_alpha == '0) && (r_inverse_mass == '0))
                          || ((r_time_step == '0) && w_side_p.compnz);
            r_e1_md    <= w_side_p.md;
            r_e1_dneg  <= w_side_p.dneg;
        end
    end

    // ---------------- E2: w*|C| and partial products of denom*length --------
    logic [3*CA-1:0]             w_denom_pad;
    logic [BASE_W-1:0]           r_e2_base;
    logic [2:0][CA+LEN_W-1:0]    r_e2_dpp;
    logic [2:0][DIFF_W-1:0]      r_e2_md;
    t_flags                      r_e2_flags;

    assign w_denom_pad = (3 * CA)'(r_e1_denom);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e2_base <= BASE_W'(r_inverse_mass) * BASE_W'(r_e1_magc);
            for (int j = 0; j < 3; j++) begin
                r_e2_dpp[j] <= (CA + LEN_W)'(w_denom_pad[j*CA +: CA])
                             * (CA + LEN_W)'(r_e1_len);
            end
            r_e2_md    <= r_e1_md;
            r_e2_flags <= '{dneg: r_e1_dneg, cneg: r_e1_cneg, zero: r_e1_zero};
        end
    end

    // ---------------- E3: sum denominator, numerator partial products -------
    logic [3*CB-1:0]                w_base_pad;
    logic [DEN_W-1:0]               r_e3_den;
    logic [2:0][2:0][CB+DIFF_W-1:0] r_e3_npp;
    t_flags                         r_e3_flags;

    assign w_base_pad = (3 * CB)'(r_e2_base);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e3_den <= DEN_W'((3 * CA + LEN_W)'(r_e2_dpp[0])
                             + ((3 * CA + LEN_W)'(r_e2_dpp[1]) << CA)
                             + ((3 * CA + LEN_W)'(r_e2_dpp[2]) << (2 * CA)));
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_e3_npp[i][j] <= (CB + DIFF_W)'(w_base_pad[j*CB +: CB])
                                    * (CB + DIFF_W)'(r_e2_md[i]);
                end
            end
            r_e3_flags <= r_e2_flags;
        end
    end

    // ---------------- E4: sum numerators ----------------
    logic [2:0][NUM_W-1:0] r_e4_num;
    logic [DEN_W-1:0]      r_e4_den;
    t_flags                r_e4_flags;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_e4_num[i] <= NUM_W'((3 * CB + DIFF_W)'(r_e3_npp[i][0])
                                    + ((3 * CB + DIFF_W)'(r_e3_npp[i][1]) << CB)
                                    + ((3 * CB + DIFF_W)'(r_e3_npp[i][2]) << (2 * CB)));
            end
            r_e4_den   <= r_e3_den;
            r_e4_flags <= r_e3_flags;
        end
    end

    // ---------------- correction dividers, one per axis ----------------
    logic [2:0][QW-1:0] w_q;
    logic [2:0]         w_ovf;
    t_flags             w_flags;

    for (genvar i = 0; i < 3; i++) begin : g_axis
        dcp_div #(.NW(NUM_W), .DW(DEN_W), .QW(QW)) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r_e4_num[i]),
            .i_den (r_e4_den),
            .o_quo (w_q[i]),
            .o_ovf (w_ovf[i])
        );
    end

    dcp_delay #(.W($bits(t_flags)), .D(QW + 1)) u_flag_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (r_e4_flags),
        .o_d   (w_flags)
    );

    // ---------------- output register: sign and saturation ----------------
    logic [2:0][FIELD_W-1:0] n_first;
    logic [2:0][FIELD_W-1:0] n_second;
    t_out                    r_out;

    always_comb begin
        logic neg;
        logic qz;
        for (int i = 0; i < 3; i++) begin
            // sign of -C * L_i; a zero quotient is never negative
            qz  = !w_ovf[i] && (w_q[i] == '0);
            neg = (!w_flags.cneg != w_flags.dneg[i]) && !qz;
            n_first[i]  = f_sat(neg, w_ovf[i], w_q[i]);
            n_second[i] = f_sat(!neg && !qz, w_ovf[i], w_q[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_flags.zero) begin
                r_out <= '0;
            end else begin
                r_out <= '{move_first_x:  n_first[0],  move_first_y:  n_first[1],
                           move_first_z:  n_first[2],  move_second_x: n_second[0],
                           move_second_y: n_second[1], move_second_z: n_second[2]};
            end
        end
    end

    assign o_data = r_out;

    // ---------------- assertions ----------------
    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_stall_freezes_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAT-1] && i_stall) |=> $stable(r_vld))
        else $error("pipeline moved while the output was held");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with an empty output register");

    a_void_item_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_vld[LAT-2] && w_flags.zero) |=> (o_valid && (o_data == '0)))
        else $error("void constraint produced a nonzero correction");

endmodule

@@ tb/distance_constraint_projection_top_tb.sv @@
`timescale 1ns / 1ps
// Testbench for distance_constraint_projection_top: directed and random constraint
// transactions under several register settings, checked against a built-in predictor.
// Depends on dcp_pkg and the block's RTL only.
module distance_constraint_projection_top_tb;
    import dcp_pkg::*;

    // Correction predictor and the queue of corrections still owed by the block.
    class correction_board;
        t_out owed[$];
        int   errors;
        logic [31:0] step_reg;
        logic [31:0] mass_reg;

        function void reset_regs();
            step_reg = TIME_STEP_RESET;
            mass_reg = INVERSE_MASS_RESET;
        endfunction

        // Saturate a sign and a magnitude to the signed 32-bit range.
        function logic [31:0] clamp(bit negative, logic [127:0] m);
            logic [127:0] v;
            if (negative) begin
                v = (m > 128'h8000_0000) ? 128'h8000_0000 : m;
                return -v[31:0];
            end
            v = (m > 128'h7FFF_FFFF) ? 128'h7FFF_FFFF : m;
            return v[31:0];
        endfunction

        function t_out project(t_in c);
            logic signed [32:0] d[3];
            logic [127:0] md[3];
            logic [127:0] sum, root, trial, alpha, denom, den, base, q, magc;
            logic [31:0] pa[3], pb[3], mv;
            bit cneg, neg;
            t_out r;
            r = '0;
            pa[0] = c.first_x;  pa[1] = c.first_y;  pa[2] = c.first_z;
            pb[0] = c.second_x; pb[1] = c.second_y; pb[2] = c.second_z;
            sum = 0;
            for (int i = 0; i < 3; i++) begin
                d[i] = {pa[i][31], pa[i]} - {pb[i][31], pb[i]};
                md[i] = d[i] < 0 ? 128'(-d[i]) : 128'(d[i]);
                sum += md[i] * md[i];
            end
            // exact floor of the square root, one bit at a time
            root = 0;
            for (int b = 40; b >= 0; b--) begin
                trial = root | (128'd1 << b);
                if (trial * trial <= sum) root = trial;
            end
            if (step_reg == 0) begin
                if (c.compliance != 0) return r;
                alpha = 0;
            end else begin
                alpha = (128'(c.compliance) << 32) / (128'(step_reg) * 128'(step_reg));
            end
            denom = alpha + (128'(mass_reg) << 1);
            if (root == 0 || denom == 0) return r;
            cneg = root < 128'(c.rest_length);
            magc = cneg ? 128'(c.rest_length) - root : root - 128'(c.rest_length);
            den  = denom * root;
            base = 128'(mass_reg) * magc;
            for (int i = 0; i < 3; i++) begin
                q = (base * md[i]) / den;
                neg = (!cneg) != (d[i] < 0);
                if (q == 0) neg = 0;
                mv = clamp(neg, q);
                case (i)
                    0: r.move_first_x = mv;
                    1: r.move_first_y = mv;
                    default: r.move_first_z = mv;
                endcase
                mv = clamp(!neg && q != 0, q);
                case (i)
                    0: r.move_second_x = mv;
                    1: r.move_second_y = mv;
                    default: r.move_second_z = mv;
                endcase
            end
            return r;
        endfunction

        function void note_constraint(t_in c);
            owed.push_back(project(c));
        endfunction

        function void check_correction(t_out got);
            t_out want;
            if (owed.size() == 0) begin
                $display("%0t: unexpected correction %h", $time, got);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (want.move_first_x !== got.move_first_x)
                $display("%0t: move_first_x exp %h got %h", $time,
                         want.move_first_x, got.move_first_x);
            if (want.move_first_y !== got.move_first_y)
                $display("%0t: move_first_y exp %h got %h", $time,
                         want.move_first_y, got.move_first_y);
            if (want.move_first_z !== got.move_first_z)
                $display("%0t: move_first_z exp %h got %h", $time,
                         want.move_first_z, got.move_first_z);
            if (want.move_second_x !== got.move_second_x)
                $display("%0t: move_second_x exp %h got %h", $time,
                         want.move_second_x, got.move_second_x);
            if (want.move_second_y !== got.move_second_y)
                $display("%0t: move_second_y exp %h got %h", $time,
                         want.move_second_y, got.move_second_y);
            if (want.move_second_z !== got.move_second_z)
                $display("%0t: move_second_z exp %h got %h", $time,
                         want.move_second_z, got.move_second_z);
            if (want !== got) errors++;
        endfunction
    endclass

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 i_valid = 0;
    logic                 o_stall;
    t_in                  i_data = '0;
    logic                 o_valid;
    logic                 i_stall = 0;
    t_out                 o_data;
    logic                 i_cfg_we = 0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_TIME_STEP;
    logic [FIELD_W-1:0]   i_cfg_data = '0;

    correction_board board;
    bit  calm;              // suppress idling on both sides for a stretch
    int  quiet_cycles = 0;  // cycles since the last transaction on either channel
    bit  in_take, out_take;

    distance_constraint_projection_top dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // Sample both channels mid-cycle; the transaction completes at the next edge.
    always @(negedge i_clk) begin
        in_take  = i_rst_n && i_valid && !o_stall;
        out_take = i_rst_n && o_valid && !i_stall;
        if (out_take) board.check_correction(o_data);
    end

    // Receiver stall: about 15 percent of the time, none while calm.
    always @(posedge i_clk)
        i_stall <= !calm && ($urandom_range(99) < 15);

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if (in_take || out_take || !i_rst_n || i_cfg_we) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 20000) begin
            $display("status: fail");
            $finish;
        end
    end

    // Present one constraint and hold it until the block takes it.
    task automatic send_constraint(t_in c);
        bit taken;
        while (!calm && $urandom_range(99) < 15) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_data  <= c;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
        board.note_constraint(c);
    endtask

    // Write both registers while the pipeline is empty.
    task automatic set_regs(logic [31:0] step, logic [31:0] mass);
        i_valid <= 0;
        while (board.owed.size() != 0) @(posedge i_clk);
        i_cfg_we   <= 1;
        i_cfg_idx  <= CFG_TIME_STEP;
        i_cfg_data <= step;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_INVERSE_MASS;
        i_cfg_data <= mass;
        @(posedge i_clk);
        i_cfg_we   <= 0;
        board.step_reg = step;
        board.mass_reg = mass;
    endtask

    function automatic logic [31:0] near(logic [31:0] p);
        return p + 32'($signed($urandom_range(32'hFF << $urandom_range(16))) -
                       $signed(32'h80 << $urandom_range(16)));
    endfunction

    // Random constraint: mostly nearby particles with a plausible rest length.
    function automatic t_in random_constraint();
        t_in c;
        c.first_x = $urandom; c.first_y = $urandom; c.first_z = $urandom;
        if ($urandom_range(3) == 0) begin
            c.second_x = $urandom; c.second_y = $urandom; c.second_z = $urandom;
        end else begin
            c.second_x = near(c.first_x);
            c.second_y = near(c.first_y);
            c.second_z = near(c.first_z);
        end
        c.rest_length = ($urandom_range(3) == 0) ? 31'($urandom)
                                                 : 31'($urandom_range(32'h3_FFFF));
        case ($urandom_range(3))
            0: c.compliance = 0;
            1: c.compliance = $urandom;
            default: c.compliance = $urandom_range(16'hFFFF);
        endcase
        return c;
    endfunction

    // Short directed set: coincident points, extreme coordinates and lengths.
    task automatic directed_set();
        t_in c;
        c = '0;
        send_constraint(c);                            // coincident at the origin
        c.first_x = 32'h7FFF_FFFF; c.first_y = 32'h7FFF_FFFF; c.first_z = 32'h7FFF_FFFF;
        c.second_x = 32'h8000_0000; c.second_y = 32'h8000_0000; c.second_z = 32'h8000_0000;
        send_constraint(c);                            // widest separation
        c.rest_length = 31'h7FFF_FFFF; c.compliance = 32'hFFFF_FFFF;
        send_constraint(c);
        c = '0;
        c.first_x = 32'h0001_0000; c.rest_length = 31'h0002_0000;
        send_constraint(c);                            // compressed
        c.rest_length = 31'h0000_8000;
        send_constraint(c);                            // stretched
        c.rest_length = 31'h0001_0000;
        send_constraint(c);                            // exactly at rest
        c.first_x = 32'h8000_0000; c.second_y = 32'h7FFF_FFFF; c.rest_length = 0;
        c.compliance = 32'h0000_0001;
        send_constraint(c);
        c = '0;
        c.first_z = 32'hFFFF_FFFF; c.rest_length = 31'h7FFF_FFFF;
        send_constraint(c);                            // tiny length, huge rest
        c.first_x = 32'h1234_5678; c.second_x = 32'h1234_5678;
        c.first_y = 32'hFFFF_0000; c.second_y = 32'hFFFF_0000; c.first_z = 0;
        send_constraint(c);                            // coincident away from origin
    endtask

    task automatic random_run(int count);
        for (int n = 0; n < count; n++) begin
            calm = (n >= 60 && n < 140);
            send_constraint(random_constraint());
        end
        calm = 0;
    endtask

    initial begin
        board = new();
        board.reset_regs();
        calm = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // reset values first, then a walk through the register extremes
        directed_set();
        random_run(300);
        set_regs(32'd0, 32'd0);            // no time step, no mass
        directed_set();
        random_run(200);
        set_regs(32'd1, 32'hFFFF_FFFF);    // smallest step, heaviest inverse mass
        directed_set();
        random_run(250);
        set_regs(32'hFFFF_FFFF, 32'd1);
        directed_set();
        random_run(250);
        set_regs(32'd0, 32'h0002_0000);    // no time step: compliance decides
        random_run(200);
        set_regs($urandom, $urandom_range(32'h0004_0000));
        random_run(300);
        i_valid <= 0;

        // drain, then allow the pipeline depth for anything stray
        while (board.owed.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (board.errors == 0 && board.owed.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
hw/rtl/dcp_pkg.sv
hw/rtl/dcp_delay.sv
hw/rtl/dcp_sqrt.sv
hw/rtl/dcp_div.sv
hw/rtl/distance_constraint_projection_top.sv
tb/distance_constraint_projection_top_tb.sv
